// ===== sv/grd_pkg.sv =====
`timescale 1ns / 1ps

package grd_pkg;

   localparam int FRAC_BITS            = 16;
   localparam int MAX_GRID_DIM         = 255;
   localparam int CORDIC_STEPS_DEFAULT = 16;
   localparam int CORDIC_STEPS_MAX     = 24;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 48;

   localparam logic [CSR_INDEX_W-1:0] CSR_MODE        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMNS     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEX_ORIGIN  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEX_SIZE    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHAPE_X     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHAPE_Y     = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SWEEP_ANGLE = 3'd7;

   // divider geometry
   localparam int DIV_NUM_W = 34;
   localparam int DIV_QBITS = 33;
   localparam int DIV_DEN_W = 9;

   // angle constants in q.30
   localparam logic signed [44:0] QPI      = 45'sd3373259426;
   localparam logic signed [44:0] QHALF_PI = 45'sd1686629713;
   localparam logic signed [44:0] QTWO_PI  = 45'sd6746518852;
   localparam logic signed [33:0] QGAIN    = 34'sd652032874;

   localparam int CORDIC_FIXED_LAT = 14;
   localparam int PIPE_FIXED_LAT   = 40;

   typedef struct packed {
      logic [7:0] column;
      logic [7:0] row;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [23:0] tex_u;
      logic signed [23:0] tex_v;
      logic [15:0]        vertex_index;
      logic               cell_valid;
      logic [15:0]        index_a;
      logic [15:0]        index_b;
      logic [15:0]        index_c;
      logic [15:0]        index_d;
      logic [15:0]        index_e;
      logic [15:0]        index_f;
   } rsp_type;

   function automatic int grd_latency(input int steps);
      return steps + CORDIC_FIXED_LAT + PIPE_FIXED_LAT;
   endfunction

   function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
      logic signed [33:0] a;
      unique case (idx)
         5'd0:    a = 34'sd843314856;
         5'd1:    a = 34'sd497837829;
         5'd2:    a = 34'sd263043836;
         5'd3:    a = 34'sd133525158;
         5'd4:    a = 34'sd67021686;
         5'd5:    a = 34'sd33543515;
         5'd6:    a = 34'sd16775850;
         5'd7:    a = 34'sd8388437;
         5'd8:    a = 34'sd4194282;
         5'd9:    a = 34'sd2097149;
         5'd10:   a = 34'sd1048575;
         5'd11:   a = 34'sd524287;
         5'd12:   a = 34'sd262143;
         5'd13:   a = 34'sd131071;
         5'd14:   a = 34'sd65535;
         5'd15:   a = 34'sd32767;
         5'd16:   a = 34'sd16383;
         5'd17:   a = 34'sd8191;
         5'd18:   a = 34'sd4095;
         5'd19:   a = 34'sd2047;
         5'd20:   a = 34'sd1023;
         5'd21:   a = 34'sd511;
         5'd22:   a = 34'sd255;
         5'd23:   a = 34'sd127;
         default: a = 34'sd0;
      endcase
      return a;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > 64'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (x < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [63:0] x);
      logic signed [23:0] r;
      if (x > 64'sd8388607) begin
         r = 24'sh7fffff;
      end else if (x < -64'sd8388608) begin
         r = 24'sh800000;
      end else begin
         r = x[23:0];
      end
      return r;
   endfunction

endpackage

// ===== sv/grd_div.sv =====
`timescale 1ns / 1ps

module grd_div (
   input  logic                                    clock,
   input  logic signed [grd_pkg::DIV_NUM_W-1:0]    num,
   input  logic        [grd_pkg::DIV_DEN_W-1:0]    den,
   output logic signed [grd_pkg::DIV_NUM_W-1:0]    quo
);
   import grd_pkg::*;

   typedef struct packed {
      logic [DIV_QBITS-1:0] mag;
      logic [DIV_QBITS-1:0] q;
      logic [DIV_DEN_W-1:0] rem;
      logic [DIV_DEN_W-1:0] den;
      logic                 neg;
   } div_stage_type;

   function automatic div_stage_type div_step(input div_stage_type s);
      div_stage_type r;
      logic [DIV_DEN_W:0] trial;
      r     = s;
      trial = {s.rem, s.mag[DIV_QBITS-1]};
      r.mag = {s.mag[DIV_QBITS-2:0], 1'b0};
      if (trial >= {1'b0, s.den}) begin
         r.rem = DIV_DEN_W'(trial - {1'b0, s.den});
         r.q   = {s.q[DIV_QBITS-2:0], 1'b1};
      end else begin
         r.rem = trial[DIV_DEN_W-1:0];
         r.q   = {s.q[DIV_QBITS-2:0], 1'b0};
      end
      return r;
   endfunction

   div_stage_type                   st_ff [DIV_QBITS];
   div_stage_type                   st_in [DIV_QBITS];
   div_stage_type                   head;
   logic signed [DIV_NUM_W-1:0]     neg_num;
   logic signed [DIV_NUM_W-1:0]     quo_ff;
   logic signed [DIV_NUM_W-1:0]     quo_in;
   logic signed [DIV_NUM_W-1:0]     qz;

   always_comb begin
      neg_num  = -num;
      head.neg = num[DIV_NUM_W-1];
      head.mag = num[DIV_NUM_W-1] ? neg_num[DIV_QBITS-1:0] : num[DIV_QBITS-1:0];
      head.q   = '0;
      head.rem = '0;
      head.den = den;
      st_in[0] = div_step(head);
   end

   for (genvar i = 1; i < DIV_QBITS; i++) begin : g_stage
      always_comb begin
         st_in[i] = div_step(st_ff[i-1]);
      end
   end

   // floor for negative numerators
   always_comb begin
      qz = $signed({1'b0, st_ff[DIV_QBITS-1].q});
      if (st_ff[DIV_QBITS-1].neg) begin
         quo_in = (st_ff[DIV_QBITS-1].rem != '0) ? -qz - 34'sd1 : -qz;
      end else begin
         quo_in = qz;
      end
   end

   always_ff @(posedge clock) begin
      st_ff  <= st_in;
      quo_ff <= quo_in;
   end

   assign quo = quo_ff;

endmodule

// ===== sv/grd_cordic.sv =====
`timescale 1ns / 1ps

module grd_cordic #(
   parameter int CORDIC_STEPS = grd_pkg::CORDIC_STEPS_DEFAULT
) (
   input  logic               clock,
   input  logic signed [44:0] theta,
   output logic signed [33:0] cos_q30,
   output logic signed [33:0] sin_q30
);
   import grd_pkg::*;

   localparam int RED_STEPS = 11;

   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
      logic               neg;
   } rot_type;

   logic [43:0]        red_ff [RED_STEPS+1];
   logic [43:0]        red_in [RED_STEPS+1];
   rot_type            rot_ff [CORDIC_STEPS+1];
   rot_type            rot_in [CORDIC_STEPS+1];
   logic signed [33:0] cos_ff, cos_in, sin_ff, sin_in;
   logic signed [44:0] wrap;
   logic signed [44:0] r0, r1;

   // bring theta into [0, 2pi) by conditional subtraction of 2pi multiples
   always_comb begin
      wrap = theta + (QTWO_PI <<< (RED_STEPS - 1));
      red_in[0] = theta[44] ? wrap[43:0] : theta[43:0];
   end

   for (genvar j = 0; j < RED_STEPS; j++) begin : g_red
      localparam logic [43:0] SUB = 44'(QTWO_PI) << (RED_STEPS - 1 - j);
      always_comb begin
         red_in[j+1] = (red_ff[j] >= SUB) ? red_ff[j] - SUB : red_ff[j];
      end
   end

   // fold into [-pi/2, pi/2]
   always_comb begin
      r0 = $signed({1'b0, red_ff[RED_STEPS]});
      r1 = (r0 > QPI) ? r0 - QTWO_PI : r0;
      rot_in[0].x   = QGAIN;
      rot_in[0].y   = '0;
      rot_in[0].neg = 1'b0;
      rot_in[0].z   = r1[33:0];
      if (r1 > QHALF_PI) begin
         rot_in[0].z   = 34'(r1 - QPI);
         rot_in[0].neg = 1'b1;
      end else if (r1 < -QHALF_PI) begin
         rot_in[0].z   = 34'(r1 + QPI);
         rot_in[0].neg = 1'b1;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      localparam logic signed [33:0] ANG = atan_q30(5'(i));
      always_comb begin
         rot_in[i+1] = rot_ff[i];
         if (!rot_ff[i].z[33]) begin
            rot_in[i+1].x = rot_ff[i].x - (rot_ff[i].y >>> i);
            rot_in[i+1].y = rot_ff[i].y + (rot_ff[i].x >>> i);
            rot_in[i+1].z = rot_ff[i].z - ANG;
         end else begin
            rot_in[i+1].x = rot_ff[i].x + (rot_ff[i].y >>> i);
            rot_in[i+1].y = rot_ff[i].y - (rot_ff[i].x >>> i);
            rot_in[i+1].z = rot_ff[i].z + ANG;
         end
      end
   end

   always_comb begin
      cos_in = rot_ff[CORDIC_STEPS].neg ? -rot_ff[CORDIC_STEPS].x : rot_ff[CORDIC_STEPS].x;
      sin_in = rot_ff[CORDIC_STEPS].neg ? -rot_ff[CORDIC_STEPS].y : rot_ff[CORDIC_STEPS].y;
   end

   always_ff @(posedge clock) begin
      red_ff <= red_in;
      rot_ff <= rot_in;
      cos_ff <= cos_in;
      sin_ff <= sin_in;
   end

   assign cos_q30 = cos_ff;
   assign sin_q30 = sin_ff;

endmodule

// ===== sv/grid_sector_mesh_vertex_generator.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// req       in         start, busy          req_item (column, row)
// rsp       out        rsp_valid strobe     rsp_item (position, texture, indices)
// csr       in         csr_we               csr_index, csr_wdata
//
// one item per cycle while busy is low; each result passes the 33-stage divider, the angle reduction
// and the CORDIC rotation stages before rsp_valid rises.
// synchronous reset clears the valid line and loads the configuration registers with their defaults;
// busy is high in reset and for the first cycle after it.
// the receiver cannot stall, so the pipeline never holds.
module grid_sector_mesh_vertex_generator #(
   parameter int CORDIC_STEPS = grd_pkg::CORDIC_STEPS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  grd_pkg::req_type                     req_item,
   output logic                                 rsp_valid,
   output grd_pkg::rsp_type                     rsp_item,
   input  logic                                 csr_we,
   input  logic [grd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [grd_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import grd_pkg::*;

   localparam int LC  = CORDIC_STEPS + CORDIC_FIXED_LAT;
   localparam int LAT = grd_latency(CORDIC_STEPS);

   typedef struct packed {
      logic [15:0] vi;
      logic        starts_cell;
      logic [7:0]  cols;
   } side_type;

   typedef struct packed {
      logic signed [31:0] gx;
      logic signed [31:0] gy;
      logic signed [31:0] d;
      logic signed [23:0] u;
      logic signed [23:0] v;
   } line_type;

   // configuration
   logic               mode_ff;
   logic [7:0]         columns_ff, rows_ff;
   logic [47:0]        origin_ff, size_ff;
   logic signed [31:0] shape_x_ff, shape_y_ff;
   logic signed [19:0] sweep_ff;
   logic               busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= 1'b0;
         columns_ff <= 8'd1;
         rows_ff    <= 8'd1;
         origin_ff  <= '0;
         size_ff    <= 48'd1099511693312;
         shape_x_ff <= 32'sd65536;
         shape_y_ff <= 32'sd65536;
         sweep_ff   <= 20'sd411775;
         busy_ff    <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
         if (csr_we) begin
            unique case (csr_index)
               CSR_MODE:        mode_ff    <= csr_wdata[0];
               CSR_COLUMNS:     columns_ff <= csr_wdata[7:0];
               CSR_ROWS:        rows_ff    <= csr_wdata[7:0];
               CSR_TEX_ORIGIN:  origin_ff  <= csr_wdata;
               CSR_TEX_SIZE:    size_ff    <= csr_wdata;
               CSR_SHAPE_X:     shape_x_ff <= csr_wdata[31:0];
               CSR_SHAPE_Y:     shape_y_ff <= csr_wdata[31:0];
               CSR_SWEEP_ANGLE: sweep_ff   <= csr_wdata[19:0];
            endcase
         end
      end
   end

   assign busy = busy_ff | reset;

   logic signed [23:0] ou, ov, tw, th;
   assign ou = origin_ff[47:24];
   assign ov = origin_ff[23:0];
   assign tw = size_ff[47:24];
   assign th = size_ff[23:0];

   // input stage
   logic [7:0]         cols, rows;
   logic signed [32:0] pu, pv;
   logic signed [33:0] nu_ff, nu_in, nv_ff, nv_in;
   logic [8:0]         du_ff, du_in, dv_ff, dv_in;
   side_type           side_ff [LAT-1];
   side_type           side_in;
   logic               vld_ff [LAT];
   logic               accept;

   assign accept = start && !busy;

   always_comb begin
      cols = (columns_ff == 8'd0) ? 8'd1 :
             ((columns_ff > 8'(MAX_GRID_DIM)) ? 8'(MAX_GRID_DIM) : columns_ff);
      rows = (rows_ff == 8'd0) ? 8'd1 :
             ((rows_ff > 8'(MAX_GRID_DIM)) ? 8'(MAX_GRID_DIM) : rows_ff);
      pu    = $signed({1'b0, req_item.column}) * tw;
      pv    = $signed({1'b0, req_item.row}) * th;
      nu_in = $signed({pu, 1'b0}) + $signed({26'd0, cols});
      nv_in = $signed({pv, 1'b0}) + $signed({26'd0, rows});
      du_in = {cols, 1'b0};
      dv_in = {rows, 1'b0};
      side_in.vi   = 16'({8'd0, req_item.column} +
                         17'(req_item.row) * 17'({1'b0, cols} + 9'd1));
      side_in.starts_cell = (req_item.column < cols) && (req_item.row < rows);
      side_in.cols = cols;
   end

   always_ff @(posedge clock) begin
      nu_ff <= nu_in;
      nv_ff <= nv_in;
      du_ff <= du_in;
      dv_ff <= dv_in;
      side_ff[0] <= side_in;
      for (int k = 1; k < LAT - 1; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= accept;
         for (int k = 1; k < LAT; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // texture coordinate dividers
   logic signed [33:0] qu, qv;

   grd_div u_div_u (.clock(clock), .num(nu_ff), .den(du_ff), .quo(qu));
   grd_div u_div_v (.clock(clock), .num(nv_ff), .den(dv_ff), .quo(qv));

   logic signed [23:0] u_ff, u_in, v_ff, v_in;

   always_comb begin
      u_in = sat24(64'(qu) + 64'(ou));
      v_in = sat24(64'(qv) + 64'(ov));
   end

   // products
   logic signed [24:0] omv;
   logic signed [32:0] sdiff;
   logic signed [55:0] gx_ff, gx_in;
   logic signed [56:0] gy_ff, gy_in, dp_ff, dp_in;
   logic signed [44:0] pp_ff, pp_in;
   logic signed [23:0] mu_ff, mv_ff;

   always_comb begin
      omv   = (25'sd1 <<< FRAC_BITS) - 25'(v_ff);
      sdiff = 33'(shape_x_ff) - 33'(shape_y_ff);
      gx_in = shape_x_ff * u_ff;
      gy_in = shape_y_ff * omv;
      dp_in = sdiff * u_ff;
      pp_in = omv * sweep_ff;
   end

   // rounding and saturation
   line_type           line_ff [LC+2];
   line_type           line_in;
   logic signed [44:0] theta_ff, theta_in;
   logic signed [63:0] rnd_f;

   always_comb begin
      rnd_f      = 64'sd1 <<< (FRAC_BITS - 1);
      line_in.gx = sat32((64'(gx_ff) + rnd_f) >>> FRAC_BITS);
      line_in.gy = sat32((64'(gy_ff) + rnd_f) >>> FRAC_BITS);
      line_in.d  = sat32(((64'(dp_ff) + rnd_f) >>> FRAC_BITS) + 64'(shape_y_ff));
      line_in.u  = mu_ff;
      line_in.v  = mv_ff;
      theta_in   = 45'((64'(pp_ff) + (64'sd1 <<< (2 * FRAC_BITS - 31)))
                       >>> (2 * FRAC_BITS - 30));
   end

   always_ff @(posedge clock) begin
      u_ff     <= u_in;
      v_ff     <= v_in;
      gx_ff    <= gx_in;
      gy_ff    <= gy_in;
      dp_ff    <= dp_in;
      pp_ff    <= pp_in;
      mu_ff    <= u_ff;
      mv_ff    <= v_ff;
      theta_ff <= theta_in;
      line_ff[0] <= line_in;
      for (int k = 1; k < LC + 2; k++) begin
         line_ff[k] <= line_ff[k-1];
      end
   end

   // sector rotation
   logic signed [33:0] cs, sn;

   grd_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock   (clock),
      .theta   (theta_ff),
      .cos_q30 (cs),
      .sin_q30 (sn)
   );

   logic signed [65:0] xp_ff, xp_in, yp_ff, yp_in;

   always_comb begin
      xp_in = line_ff[LC].d * cs;
      yp_in = line_ff[LC].d * sn;
   end

   // output
   rsp_type            rsp_ff, rsp_in;
   side_type           so;
   line_type           lo;
   logic [15:0]        step_b;

   always_comb begin
      so = side_ff[LAT-2];
      lo = line_ff[LC+1];
      step_b = 16'({8'd0, so.cols} + 16'd1);
      rsp_in.tex_u        = lo.u;
      rsp_in.tex_v        = lo.v;
      rsp_in.vertex_index = so.vi;
      rsp_in.cell_valid   = so.starts_cell;
      if (mode_ff) begin
         rsp_in.pos_x = sat32(64'((xp_ff + (66'sd1 <<< 29)) >>> 30));
         rsp_in.pos_y = sat32(64'((yp_ff + (66'sd1 <<< 29)) >>> 30));
      end else begin
         rsp_in.pos_x = lo.gx;
         rsp_in.pos_y = lo.gy;
      end
      if (so.starts_cell) begin
         rsp_in.index_a = so.vi;
         rsp_in.index_b = so.vi + step_b;
         rsp_in.index_c = so.vi + 16'd1;
         rsp_in.index_d = so.vi + step_b + 16'd1;
         rsp_in.index_e = so.vi + 16'd1;
         rsp_in.index_f = so.vi + step_b;
      end else begin
         rsp_in.index_a = '0;
         rsp_in.index_b = '0;
         rsp_in.index_c = '0;
         rsp_in.index_d = '0;
         rsp_in.index_e = '0;
         rsp_in.index_f = '0;
      end
   end

   always_ff @(posedge clock) begin
      xp_ff  <= xp_in;
      yp_ff  <= yp_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = vld_ff[LAT-1];
   assign rsp_item  = rsp_ff;

endmodule

// ===== sv/grd_chk.sv =====
`timescale 1ns / 1ps

module grd_chk #(
   parameter int CORDIC_STEPS = grd_pkg::CORDIC_STEPS_DEFAULT
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_valid,
   input grd_pkg::rsp_type                  rsp_item
);
   import grd_pkg::*;

   localparam int LAT = grd_latency(CORDIC_STEPS);

   a_rst_quiet : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe after reset");

   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("item lost in pipeline");

   a_no_cell : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.cell_valid) |->
      (rsp_item.index_a == 16'd0 && rsp_item.index_b == 16'd0 &&
       rsp_item.index_c == 16'd0 && rsp_item.index_d == 16'd0 &&
       rsp_item.index_e == 16'd0 && rsp_item.index_f == 16'd0))
      else $error("indices set outside a cell");

   a_cell : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.cell_valid) |->
      (rsp_item.index_a == rsp_item.vertex_index &&
       rsp_item.index_c == 16'(rsp_item.index_a + 16'd1) &&
       rsp_item.index_e == rsp_item.index_c &&
       rsp_item.index_f == rsp_item.index_b &&
       rsp_item.index_d == 16'(rsp_item.index_b + 16'd1)))
      else $error("cell indices inconsistent");

endmodule

bind grid_sector_mesh_vertex_generator grd_chk #(.CORDIC_STEPS(CORDIC_STEPS)) u_grd_chk (.*);
